// ===== sv/lgt_pkg.sv =====
// shared constants and codes for the life generation torus unit
package lgt_pkg;

  localparam int GRID_SIZE = 256;
  localparam int ROW_W     = $clog2(GRID_SIZE);
  localparam int COORD_W   = 8;
  localparam int MODE_W    = 2;

  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(GRID_SIZE - 1);

  typedef logic [GRID_SIZE-1:0] row_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_WRITE = 2'd0,
    MODE_READ  = 2'd1,
    MODE_STEP  = 2'd2
  } mode_e;

endpackage

// ===== sv/life_generation_torus_unit.sv =====
// life board held as rows in ram, with cell access and whole-board generation step
//
//   channel | direction | signals
//   in      | input     | in_valid_i, in_stall_o, mode_i, row_i, col_i, cell_value_i
//   out     | output    | out_valid_o, out_stall_i, read_value_o, done_mode_o
//
// one item at a time; a cell read or write passes through the cell state and the response state to the result register
// a generation sweeps the board with one ram row read and one row write per cycle,
//   the new row computed from three row registers while rewriting the board in place
// after reset a clearing pass writes dead rows to every row of the board; no transfer meanwhile
// a result waits in the output register while out_stall_i is high
module life_generation_torus_unit import lgt_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [MODE_W-1:0]  mode_i,
  input  logic [COORD_W-1:0] row_i,
  input  logic [COORD_W-1:0] col_i,
  input  logic               cell_value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               read_value_o,
  output logic [MODE_W-1:0]  done_mode_o
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CELL,
    S_LOAD_LAST,
    S_LOAD_FIRST,
    S_SWEEP,
    S_RESP
  } state_e;

  state_e             state_q;
  logic [ROW_W-1:0]   r_q;
  logic [MODE_W-1:0]  mode_q;
  logic [ROW_W-1:0]   row_q;
  logic [ROW_W-1:0]   col_q;
  logic               val_q;
  logic               inside_q;
  logic               res_q;
  logic               out_valid_q;
  logic               read_value_q;
  logic [MODE_W-1:0]  done_mode_q;
  row_t               prev_q;
  row_t               cur_q;
  row_t               first_q;

  logic               ram_we;
  logic [ROW_W-1:0]   ram_waddr;
  row_t               ram_wdata;
  logic [ROW_W-1:0]   ram_raddr;
  row_t               ram_rdata;

  logic               in_xfer;
  logic               slot_free;
  logic [ROW_W-1:0]   row_a;
  logic [ROW_W-1:0]   col_a;
  logic               inside_a;
  logic [ROW_W:0]     ahead_sum;
  logic [ROW_W-1:0]   ahead_row;
  row_t               below_row;
  row_t               new_row;
  row_t               cell_row;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign slot_free  = !out_valid_q || !out_stall_i;

  assign row_a    = ROW_W'(row_i);
  assign col_a    = ROW_W'(col_i);
  assign inside_a = (32'(row_i) < 32'(GRID_SIZE)) && (32'(col_i) < 32'(GRID_SIZE));

  // row two ahead of the one being rewritten, wrapped round the board
  assign ahead_sum = {1'b0, r_q} + (ROW_W+1)'(2);
  assign ahead_row = (32'(ahead_sum) >= 32'(GRID_SIZE)) ?
                     ROW_W'(32'(ahead_sum) - 32'(GRID_SIZE)) : ROW_W'(ahead_sum);

  // old row 0 was overwritten first, so the bottom row uses the saved copy
  assign below_row = (r_q == LAST_ROW) ? first_q : ram_rdata;

  always_comb begin
    cell_row        = ram_rdata;
    cell_row[col_q] = val_q;
  end

  lgt_row_rule u_rule (
    .up_i   (prev_q),
    .mid_i  (cur_q),
    .down_i (below_row),
    .nxt_o  (new_row)
  );

  lgt_ram #(
    .WIDTH (GRID_SIZE),
    .DEPTH (GRID_SIZE)
  ) u_board (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = r_q;
    ram_wdata = new_row;
    ram_raddr = ahead_row;
    case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = '0;
      end
      S_IDLE: begin
        ram_raddr = (mode_i == MODE_STEP) ? LAST_ROW : row_a;
      end
      S_LOAD_LAST: begin
        ram_raddr = '0;
      end
      S_LOAD_FIRST: begin
        ram_raddr = ROW_W'(1);
      end
      S_CELL: begin
        ram_we    = (mode_q == MODE_WRITE) && inside_q;
        ram_waddr = row_q;
        ram_wdata = cell_row;
      end
      S_SWEEP: begin
        ram_we = 1'b1;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      r_q          <= '0;
      mode_q       <= '0;
      row_q        <= '0;
      col_q        <= '0;
      val_q        <= 1'b0;
      inside_q     <= 1'b0;
      res_q        <= 1'b0;
      out_valid_q  <= 1'b0;
      read_value_q <= 1'b0;
      done_mode_q  <= '0;
      prev_q       <= '0;
      cur_q        <= '0;
      first_q      <= '0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLEAR: begin
          r_q <= r_q + ROW_W'(1);
          if (r_q == LAST_ROW) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_xfer) begin
            mode_q   <= mode_i;
            row_q    <= row_a;
            col_q    <= col_a;
            val_q    <= cell_value_i;
            inside_q <= inside_a;
            res_q    <= 1'b0;
            case (mode_i)
              MODE_WRITE, MODE_READ: state_q <= S_CELL;
              MODE_STEP:             state_q <= S_LOAD_LAST;
              default:               state_q <= S_RESP;
            endcase
          end
        end
        S_CELL: begin
          res_q   <= (mode_q == MODE_READ) && inside_q && ram_rdata[col_q];
          state_q <= S_RESP;
        end
        S_LOAD_LAST: begin
          prev_q  <= ram_rdata;
          state_q <= S_LOAD_FIRST;
        end
        S_LOAD_FIRST: begin
          cur_q   <= ram_rdata;
          first_q <= ram_rdata;
          r_q     <= '0;
          state_q <= S_SWEEP;
        end
        S_SWEEP: begin
          prev_q <= cur_q;
          cur_q  <= below_row;
          r_q    <= r_q + ROW_W'(1);
          if (r_q == LAST_ROW) begin
            r_q     <= '0;
            state_q <= S_RESP;
          end
        end
        S_RESP: begin
          if (slot_free) begin
            out_valid_q  <= 1'b1;
            read_value_q <= res_q;
            done_mode_q  <= mode_q;
            state_q      <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_value_o = read_value_q;
  assign done_mode_o  = done_mode_q;

  // board is only written while clearing, patching a cell or sweeping a generation
  a_ram_write_states: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_CLEAR || state_q == S_CELL || state_q == S_SWEEP))
    else $error("board written outside a writing state");

  // a new result only appears after the response state
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_RESP)
    else $error("result raised without a response state");

  // a live read value only comes from a cell read
  a_read_value_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && read_value_q) |-> (done_mode_q == MODE_READ))
    else $error("read value set for a non-read operation");

  // the sweep covers every row before finishing
  a_sweep_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SWEEP && r_q != LAST_ROW) |=> (state_q == S_SWEEP))
    else $error("generation sweep left early");

endmodule

// ===== sv/lgt_ram.sv =====
// generic single-write, single-read synchronous ram with registered read
module lgt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/lgt_row_rule.sv =====
// b3/s23 rule applied across one whole row, with wraparound between columns
module lgt_row_rule import lgt_pkg::*; (
  input  row_t up_i,
  input  row_t mid_i,
  input  row_t down_i,
  output row_t nxt_o
);

  always_comb begin
    logic [3:0] cnt;
    int         lc;
    int         rc;
    nxt_o = '0;
    for (int c = 0; c < GRID_SIZE; c++) begin
      lc  = (c + GRID_SIZE - 1) % GRID_SIZE;
      rc  = (c + 1) % GRID_SIZE;
      cnt = 4'(up_i[lc])   + 4'(up_i[c])   + 4'(up_i[rc]) +
            4'(mid_i[lc])                  + 4'(mid_i[rc]) +
            4'(down_i[lc]) + 4'(down_i[c]) + 4'(down_i[rc]);
      nxt_o[c] = (cnt == 4'd3) || (mid_i[c] && (cnt == 4'd2));
    end
  end

endmodule
